// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Holds the opcode and status codes and the per-cell control struct.
// No dependencies.
package spq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PEEK   = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int PRIO_BITS   = 8;
    localparam int OUT_BITS    = 32;
    localparam int OCC_BITS    = 5;

    // Broadcast to every cell of the chain in the cycle of a transfer
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted priority queue built as a chain of QUEUE_DEPTH cells, head at cell 0.
// The result of an operation is registered at its transfer and presented in the cycle after it.
// Throughput: one operation per cycle while the consumer takes results; every cell compares and shifts at once.
// Reset: asynchronous, active low; all cells empty, count zero, no clearing pass.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           opcode,
    input  logic [spq_pkg::OUT_BITS-1:0]         item_value,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] item_priority,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic [spq_pkg::OUT_BITS-1:0]         out_value,
    output logic signed [spq_pkg::PRIO_BITS-1:0] out_priority,
    output logic [spq_pkg::OCC_BITS-1:0]         occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Per-cell views, index 0 is the head of the queue
    logic [QUEUE_DEPTH-1:0]       cell_lt;
    logic [QUEUE_DEPTH-1:0]       cell_valid;
    logic [VALUE_BITS-1:0]        cell_value [QUEUE_DEPTH];
    logic signed [PRIO_BITS-1:0]  cell_prio  [QUEUE_DEPTH];

    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         out_valid_reg;
    status_t                      status_reg, status_next;
    logic [OUT_BITS-1:0]          out_value_reg, out_value_next;
    logic signed [PRIO_BITS-1:0]  out_prio_reg, out_prio_next;
    logic [CNT_W-1:0]             occ_reg;

    logic                         xfer;
    logic                         full;
    logic                         empty;
    cell_ctrl_t                   ctrl;
    logic [VALUE_BITS-1:0]        new_value;

    // Take a new operation whenever the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign xfer     = in_valid && in_ready;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_value = VALUE_BITS'(item_value);

    // Decode the operation; refused or empty cases leave the chain untouched
    always_comb
    begin
        ctrl           = '0;
        count_next     = count_reg;
        status_next    = ST_OK;
        out_value_next = '0;
        out_prio_next  = '0;
        unique case (opcode) inside
            OP_INSERT:
            begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.insert = xfer;
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_PEEK, OP_REMOVE:
            begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    out_value_next = OUT_BITS'(cell_value[0]);
                    out_prio_next  = cell_prio[0];
                    if (opcode == OP_REMOVE) begin
                        ctrl.remove = xfer;
                        count_next  = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                // Unused code: report ok and hold the queue
                status_next = ST_OK;
            end
        endcase
    end

    // The chain: each cell sees its left and right neighbours
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                        l_lt, l_valid, r_valid;
        logic [VALUE_BITS-1:0]       l_value, r_value;
        logic signed [PRIO_BITS-1:0] l_prio, r_prio;

        if (i == 0) begin : g_head
            assign l_lt    = 1'b0;
            assign l_valid = 1'b0;
            assign l_value = '0;
            assign l_prio  = '0;
        end else begin : g_body
            assign l_lt    = cell_lt[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_value = cell_value[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
            assign r_prio  = '0;
        end else begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        spq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .new_prio    (item_priority),
            .left_lt     (l_lt),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .left_prio   (l_prio),
            .right_valid (r_valid),
            .right_value (r_value),
            .right_prio  (r_prio),
            .lt          (cell_lt[i]),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i])
        );
    end

    // Control state: entry count and result-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (xfer) begin
                count_reg <= count_next;
            end
            if (xfer) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on transfer, hold while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (xfer) begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
            out_prio_reg  <= out_prio_next;
            occ_reg       <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = OCC_BITS'(occ_reg);

`ifndef SYNTHESIS
    // Count register tracks the number of occupied cells
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(cell_valid)))
        else $error("entry count disagrees with occupied cells");

    // Occupied cells always form an unbroken run from the head
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("gap in occupied cells");

    // The head never holds a lower priority than its neighbour
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> (cell_prio[0] >= cell_prio[1]))
        else $error("head out of priority order");

    // An insert into a full queue leaves the count unchanged
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && full && opcode == OP_INSERT) |=> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("insert accepted while full");
`endif

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: valid flag, value and priority.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue_top.
module spq_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  spq_pkg::cell_ctrl_t               ctrl,
    input  logic [VALUE_BITS-1:0]             new_value,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] new_prio,
    input  logic                              left_lt,
    input  logic                              left_valid,
    input  logic [VALUE_BITS-1:0]             left_value,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] left_prio,
    input  logic                              right_valid,
    input  logic [VALUE_BITS-1:0]             right_value,
    input  logic signed [spq_pkg::PRIO_BITS-1:0] right_prio,
    output logic                              lt,
    output logic                              valid,
    output logic [VALUE_BITS-1:0]             value,
    output logic signed [spq_pkg::PRIO_BITS-1:0] prio
);
    import spq_pkg::*;

    logic                        valid_reg, valid_next;
    logic [VALUE_BITS-1:0]       value_reg, value_next;
    logic signed [PRIO_BITS-1:0] prio_reg, prio_next;

    // Strictly lower priority or empty: the new item goes in front of this slot
    assign lt = !valid_reg || (prio_reg < new_prio);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.insert) begin
            if (lt) begin
                if (left_lt) begin
                    valid_next = left_valid;
                    value_next = left_value;
                    prio_next  = left_prio;
                end else begin
                    valid_next = 1'b1;
                    value_next = new_value;
                    prio_next  = new_prio;
                end
            end
        end else if (ctrl.remove) begin
            valid_next = right_valid;
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for sorted_priority_queue_top.
// Holds a directed table of operations, then weighted random traffic, checked against a
// mirror of the queue kept here. Depends on spq_pkg and the RTL of the queue.
module tb_top;
    import spq_pkg::*;

    // Opcode value that the block leaves without effect
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int QUEUE_DEPTH   = 16;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 625;
    localparam int TAIL_ITEMS    = 100;
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 200000;

    // One result of the block, field for field
    typedef struct packed {
        status_t     st;
        logic [31:0] val;
        logic [7:0]  pr;
        logic [4:0]  occ;
    } result_t;

    // One entry held by the mirror of the queue
    typedef struct {
        logic [31:0] val;
        logic [7:0]  pr;
    } entry_t;

    // One row of the directed table; res is used only where typed is set
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] val;
        logic [7:0]  pr;
        bit          typed;
        result_t     res;
    } step_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode        = OP_PEEK;
    logic [31:0] item_value    = '0;
    logic [7:0]  item_priority = '0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [1:0]  status;
    logic [31:0] out_value;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy;

    // Mirror of the queue contents, head first, and results still owed by the block
    entry_t  held_entries[$];
    result_t awaited_results[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int gap_odds    = 0;    // chance in ten of a sender gap before an item
    int stall_odds  = 2;    // chance in ten of a receiver stall burst
    bit quiet_tail  = 1'b0; // no idling on either side once set

    // Directed table: empty queue first, then the extremes of value and priority,
    // ties at the head, a fill to capacity and the refused insert
    step_row_t directed_steps [DIRECTED_ROWS] = '{
        '{OP_PEEK,   32'h0000_0000, 8'h00, 1'b1, '{ST_EMPTY, 32'h0, 8'h00, 5'd0}},
        '{OP_REMOVE, 32'h0000_0000, 8'h00, 1'b1, '{ST_EMPTY, 32'h0, 8'h00, 5'd0}},
        '{OP_UNUSED, 32'hFFFF_FFFF, 8'h7F, 1'b1, '{ST_OK,    32'h0, 8'h00, 5'd0}},
        '{OP_INSERT, 32'hFFFF_FFFF, 8'h7F, 1'b1, '{ST_OK,    32'h0, 8'h00, 5'd1}},
        '{OP_INSERT, 32'h0000_0000, 8'h80, 1'b1, '{ST_OK,    32'h0, 8'h00, 5'd2}},
        '{OP_INSERT, 32'h0000_0011, 8'h05, 1'b1, '{ST_OK,    32'h0, 8'h00, 5'd3}},
        '{OP_INSERT, 32'h0000_0022, 8'h05, 1'b1, '{ST_OK,    32'h0, 8'h00, 5'd4}},
        '{OP_PEEK,   32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 8'h7F, 5'd4}},
        // fill the remaining slots; a second 127 sits behind the older one
        '{OP_INSERT, 32'h8000_0000, 8'hFF, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0001, 8'h00, 1'b0, '0},
        '{OP_INSERT, 32'h5555_5555, 8'h7F, 1'b0, '0},
        '{OP_INSERT, 32'hAAAA_AAAA, 8'h80, 1'b0, '0},
        '{OP_INSERT, 32'h1234_5678, 8'h05, 1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFF, 8'h81, 1'b0, '0},
        '{OP_INSERT, 32'hDEAD_BEEF, 8'h40, 1'b0, '0},
        '{OP_INSERT, 32'h0F0F_0F0F, 8'hFE, 1'b0, '0},
        '{OP_INSERT, 32'hF0F0_F0F0, 8'h01, 1'b0, '0},
        '{OP_INSERT, 32'hCAFE_F00D, 8'h7E, 1'b0, '0},
        '{OP_INSERT, 32'h00FF_00FF, 8'hC0, 1'b0, '0},
        '{OP_INSERT, 32'hFF00_FF00, 8'h00, 1'b0, '0},
        '{OP_INSERT, 32'h9999_9999, 8'h32, 1'b1, '{ST_FULL,  32'h0, 8'h00, 5'd16}},
        '{OP_UNUSED, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK,    32'h0, 8'h00, 5'd16}},
        '{OP_REMOVE, 32'h0000_0000, 8'h00, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 8'h7F, 5'd15}},
        '{OP_REMOVE, 32'h0000_0000, 8'h00, 1'b0, '0},
        '{OP_PEEK,   32'h0000_0000, 8'h00, 1'b0, '0}
    };

    sorted_priority_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_BITS  (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .occupancy     (occupancy)
    );

    always #5 clk = ~clk;

    // Apply one operation to the mirror and return the result the block owes for it.
    // Insert goes behind every entry of equal or higher priority, so ties leave oldest first.
    function automatic result_t apply_to_mirror(input logic [1:0] op, input logic [31:0] v,
                                                input logic [7:0] p);
        result_t r;
        int      pos;
        entry_t  e;
        r.st  = ST_OK;
        r.val = '0;
        r.pr  = '0;
        case (op) inside
            OP_INSERT:
            begin
                if (held_entries.size() >= QUEUE_DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_entries.size() &&
                           $signed(held_entries[pos].pr) >= $signed(p))
                        pos++;
                    e.val = v;
                    e.pr  = p;
                    held_entries.insert(pos, e);
                end
            end
            OP_PEEK, OP_REMOVE:
            begin
                if (held_entries.size() == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.val = held_entries[0].val;
                    r.pr  = held_entries[0].pr;
                    if (op == OP_REMOVE)
                        void'(held_entries.pop_front());
                end
            end
            default:
            begin
            end
        endcase
        r.occ = 5'(held_entries.size());
        return r;
    endfunction

    // Present one operation and hold it until the transfer. Inputs only change at rising
    // edges, so the level seen at the falling edge is the one the next rising edge samples.
    task automatic push_item(input logic [1:0] op, input logic [31:0] v, input logic [7:0] p,
                             input bit typed, input result_t typed_res);
        result_t r;
        in_valid      <= 1'b1;
        opcode        <= op;
        item_value    <= v;
        item_priority <= p;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        r = apply_to_mirror(op, v, p);
        // a typed row stands as its own expectation; the mirror still advances
        awaited_results.push_back(typed ? typed_res : r);
        @(posedge clk);
    endtask

    // Drop valid for an idle burst of length n (n is at least one)
    task automatic idle_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Receiver: stall in bursts of random length, never once the quiet tail has begun
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 9) < stall_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Result checker: a transfer on the output happens at the rising edge after this
    // falling edge, so compare it against the oldest awaited result now
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $error("result transfer with none awaited: status %0d value %h",
                       status, out_value);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.st)
                begin
                    mismatches++;
                    $error("status: expected %0d, got %0d", want.st, status);
                end
                if (out_value !== want.val)
                begin
                    mismatches++;
                    $error("out_value: expected %h, got %h", want.val, out_value);
                end
                if (out_priority !== want.pr)
                begin
                    mismatches++;
                    $error("out_priority: expected %0d, got %0d",
                           $signed(want.pr), $signed(out_priority));
                end
                if (occupancy !== want.occ)
                begin
                    mismatches++;
                    $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                end
            end
        end
    end

    // Watchdog: end the run if traffic stalls far beyond any correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int          row;
        int          random_sent;
        int          seg_mode;
        int          seg_len;
        int          k;
        int          pick;
        int          narrow;
        bit          pressure_done;
        logic [1:0]  op;
        logic [7:0]  pr;
        random_sent   = 0;
        pressure_done = 1'b0;

        // hold reset, then release it at a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
            push_item(directed_steps[row].op, directed_steps[row].val, directed_steps[row].pr,
                      directed_steps[row].typed, directed_steps[row].res);

        // random part, in segments that lean towards filling, draining or a mix,
        // so the occupancy swings between empty and full many times
        while (random_sent < RANDOM_ITEMS)
        begin
            seg_mode = $urandom_range(0, 2);
            seg_len  = $urandom_range(10, 40);
            if (!quiet_tail)
            begin
                gap_odds   = $urandom_range(0, 4);
                stall_odds = $urandom_range(0, 4);
            end
            for (k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++)
            begin
                if (random_sent >= RANDOM_ITEMS - TAIL_ITEMS)
                begin
                    quiet_tail = 1'b1;
                    gap_odds   = 0;
                    stall_odds = 0;
                end

                // halfway through, hold off the sender until every result has come back
                if (!pressure_done && random_sent >= RANDOM_ITEMS / 2)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (awaited_results.size() != 0);
                    pressure_done = 1'b1;
                end

                if (gap_odds > $urandom_range(0, 9))
                    idle_sender($urandom_range(1, 6));

                pick = $urandom_range(0, 99);
                case (seg_mode)
                    0:       op = pick < 70 ? OP_INSERT : pick < 80 ? OP_PEEK :
                                  pick < 97 ? OP_REMOVE : OP_UNUSED;
                    1:       op = pick < 20 ? OP_INSERT : pick < 40 ? OP_PEEK :
                                  pick < 97 ? OP_REMOVE : OP_UNUSED;
                    default: op = pick < 45 ? OP_INSERT : pick < 65 ? OP_PEEK :
                                  pick < 97 ? OP_REMOVE : OP_UNUSED;
                endcase

                // narrow priorities give many ties; the rest spread over the full range or sit at its extremes
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    narrow = int'($urandom_range(0, 4)) - 2;
                    pr     = narrow[7:0];
                end
                else if (pick < 80)
                    pr = 8'($urandom_range(0, 255));
                else
                    pr = $urandom_range(0, 1) ? 8'h7F : 8'h80;

                push_item(op, $urandom, pr, 1'b0, '0);
                if (op != OP_UNUSED)
                    random_sent++;
            end
        end

        // drain: wait for every awaited result, then keep the clock running for anything stray
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_top.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_top.sv
tb/tb_top.sv
